FILE: hdl/rmv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmv_pkg;

    localparam int COUNT_BITS = 32;
    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 64;
    localparam int DIVISOR_W  = 32;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
    localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);
    localparam int OUT_DATA_W = 32 + SAMPLE_W + SUM_W + ROOT_W;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
    } t_div_req;

endpackage

`default_nettype wire

FILE: hdl/rmv_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend's top 'iters'
// bits are divided; the quotient ends up in the low bits of o_quotient.
module rmv_divider (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire rmv_pkg::t_div_req                    i_req,
    input  wire logic [rmv_pkg::SUM_W-1:0]            i_dividend,
    input  wire logic [rmv_pkg::DIVISOR_W-1:0]        i_divisor,
    output logic                                      o_done,
    output logic [rmv_pkg::SUM_W-1:0]                 o_quotient
);

    logic                                r_busy;
    logic                                r_done;
    logic [rmv_pkg::DIV_CNT_W-1:0]       r_cnt;
    logic [rmv_pkg::SUM_W-1:0]           r_a;
    logic [rmv_pkg::DIVISOR_W-1:0]       r_rem;
    logic [rmv_pkg::DIVISOR_W-1:0]       r_d;
    logic [rmv_pkg::DIVISOR_W:0]         n_trial;
    logic                                n_qbit;

    always_comb begin
        n_trial = {r_rem, r_a[rmv_pkg::SUM_W-1]};
        n_qbit  = (n_trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
                r_a    <= i_dividend;
                r_rem  <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                r_a <= {r_a[rmv_pkg::SUM_W-2:0], n_qbit};
                if (n_qbit) begin
                    r_rem <= rmv_pkg::DIVISOR_W'(n_trial - {1'b0, r_d});
                end else begin
                    r_rem <= n_trial[rmv_pkg::DIVISOR_W-1:0];
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rmv_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_a;

endmodule

`default_nettype wire

FILE: hdl/rmv_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Digit-by-digit integer square root, one root bit per cycle.
module rmv_isqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rmv_pkg::SUM_W-1:0]     i_radicand,
    output logic                               o_done,
    output logic [rmv_pkg::ROOT_W-1:0]         o_root
);

    localparam int REM_W = rmv_pkg::ROOT_W + 2;

    logic                               r_busy;
    logic                               r_done;
    logic [rmv_pkg::SQRT_CNT_W-1:0]     r_cnt;
    logic [rmv_pkg::SUM_W-1:0]          r_v;
    logic [REM_W-1:0]                   r_rem;
    logic [rmv_pkg::ROOT_W-1:0]         r_root;
    logic [REM_W+1:0]                   n_shift;
    logic [REM_W+1:0]                   n_trial;
    logic                               n_bit;

    always_comb begin
        n_shift = {r_rem, r_v[rmv_pkg::SUM_W-1 -: 2]};
        n_trial = {2'b00, r_root, 2'b01};
        n_bit   = (n_shift >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= rmv_pkg::SQRT_CNT_W'(rmv_pkg::ROOT_W);
                r_v    <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_v    <= {r_v[rmv_pkg::SUM_W-3:0], 2'b00};
                r_root <= {r_root[rmv_pkg::ROOT_W-2:0], n_bit};
                if (n_bit) begin
                    r_rem <= REM_W'(n_shift - n_trial);
                end else begin
                    r_rem <= n_shift[REM_W-1:0];
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rmv_pkg::SQRT_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: hdl/running_mean_variance_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Each sample takes the mean division (32 steps), the sum update, the variance division
// (64 steps) and the 32-step square root; both divisions share one serial divider. The
// variance division is skipped while fewer than two samples are held, and the mean and
// sum updates once the count is at its ceiling. A result waits while i_m_axis_tready stalls.
// Ready is high only while the sequencer is idle; the result register is separate.
// Reset: synchronous, active low; clears count, mean, sum, flag and handshakes.
module running_mean_variance_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [rmv_pkg::SAMPLE_W-1:0]        i_s_axis_tdata,  // sample
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // sample_total, mean_out, variance_out, deviation_out
    output logic [rmv_pkg::OUT_DATA_W-1:0]           o_m_axis_tdata,
    output logic                                     o_m_axis_tuser   // saturated
);

    localparam int SW = rmv_pkg::SAMPLE_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MDIV_GO, S_MDIV_WAIT, S_REST, S_MUL, S_ACC,
        S_VAR, S_VDIV_WAIT, S_SQRT_GO, S_SQRT_WAIT, S_DONE
    } t_state;

    t_state                               r_state;
    logic [rmv_pkg::COUNT_BITS-1:0]       r_count;
    logic [SW-1:0]                        r_mean;
    logic [rmv_pkg::SUM_W-1:0]            r_sum;
    logic                                 r_sat;
    logic [SW-1:0]                        r_x;
    logic [SW-1:0]                        r_delta_mag;
    logic                                 r_delta_neg;
    logic [SW-1:0]                        r_rest_mag;
    logic                                 r_rest_neg;
    logic [rmv_pkg::SUM_W-1:0]            r_prod;
    logic [rmv_pkg::SUM_W-1:0]            r_var;
    logic [rmv_pkg::ROOT_W-1:0]           r_root;
    logic                                 r_out_valid;
    logic [rmv_pkg::OUT_DATA_W-1:0]       r_out_data;
    logic                                 r_out_sat;

    rmv_pkg::t_div_req                    n_div_req;
    logic [rmv_pkg::SUM_W-1:0]            n_div_dividend;
    logic [rmv_pkg::DIVISOR_W-1:0]        n_div_divisor;
    logic                                 w_div_done;
    logic [rmv_pkg::SUM_W-1:0]            w_quot;
    logic                                 n_sqrt_start;
    logic                                 w_sqrt_done;
    logic [rmv_pkg::ROOT_W-1:0]           w_root;

    logic [SW:0]                          n_delta;
    logic [SW:0]                          n_rest;
    logic [SW:0]                          n_qs;
    logic [SW:0]                          n_newmean;
    logic [rmv_pkg::SUM_W:0]              n_sum_add;
    logic                                 n_prod_neg;
    logic                                 n_at_top;
    logic                                 n_two_plus;
    logic                                 n_out_load;

    always_comb begin
        n_delta    = {i_s_axis_tdata[SW-1], i_s_axis_tdata} - {r_mean[SW-1], r_mean};
        n_qs       = r_delta_neg ? ((SW+1)'(0) - {1'b0, w_quot[SW-1:0]})
                                 : {1'b0, w_quot[SW-1:0]};
        n_newmean  = {r_mean[SW-1], r_mean} + n_qs;
        n_rest     = {r_x[SW-1], r_x} - {r_mean[SW-1], r_mean};
        n_sum_add  = {1'b0, r_sum} + {1'b0, r_prod};
        n_prod_neg = (r_delta_neg != r_rest_neg) && (r_prod != '0);
        n_at_top   = (r_count == '1);
        n_two_plus = (r_count > rmv_pkg::COUNT_BITS'(1));
        n_out_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

        n_div_req.start = 1'b0;
        n_div_req.iters = rmv_pkg::DIV_CNT_W'(SW);
        n_div_dividend  = {r_delta_mag, (rmv_pkg::SUM_W-SW)'(0)};
        n_div_divisor   = rmv_pkg::DIVISOR_W'(r_count);
        if (r_state == S_MDIV_GO) begin
            n_div_req.start = 1'b1;
        end else if (r_state == S_VAR && n_two_plus) begin
            n_div_req.start = 1'b1;
            n_div_req.iters = rmv_pkg::DIV_CNT_W'(rmv_pkg::SUM_W);
            n_div_dividend  = r_sum;
            n_div_divisor   = rmv_pkg::DIVISOR_W'(r_count - 1'b1);
        end
        n_sqrt_start = (r_state == S_SQRT_GO);
    end

    rmv_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (n_div_req),
        .i_dividend (n_div_dividend),
        .i_divisor  (n_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    rmv_isqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_sqrt_start),
        .i_radicand (r_var),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mean      <= '0;
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {r_root, r_var, r_mean, 32'(r_count)};
                r_out_sat   <= r_sat;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_x         <= i_s_axis_tdata;
                        r_delta_neg <= n_delta[SW];
                        r_delta_mag <= n_delta[SW] ? SW'((SW+1)'(0) - n_delta)
                                                   : n_delta[SW-1:0];
                        if (n_at_top) begin
                            r_sat   <= 1'b1;
                            r_state <= S_VAR;
                        end else begin
                            r_count <= r_count + 1'b1;
                            r_state <= S_MDIV_GO;
                        end
                    end
                end
                S_MDIV_GO: begin
                    r_state <= S_MDIV_WAIT;
                end
                S_MDIV_WAIT: begin
                    if (w_div_done) begin
                        r_mean  <= n_newmean[SW-1:0];
                        r_state <= S_REST;
                    end
                end
                S_REST: begin
                    r_rest_neg <= n_rest[SW];
                    r_rest_mag <= n_rest[SW] ? SW'((SW+1)'(0) - n_rest) : n_rest[SW-1:0];
                    r_state    <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= rmv_pkg::SUM_W'(r_delta_mag) * rmv_pkg::SUM_W'(r_rest_mag);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (n_prod_neg) begin
                        r_sum <= (r_prod > r_sum) ? '0 : r_sum - r_prod;
                    end else if (n_sum_add[rmv_pkg::SUM_W]) begin
                        r_sum <= '1;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= n_sum_add[rmv_pkg::SUM_W-1:0];
                    end
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    if (n_two_plus) begin
                        r_state <= S_VDIV_WAIT;
                    end else begin
                        r_var   <= '0;
                        r_state <= S_SQRT_GO;
                    end
                end
                S_VDIV_WAIT: begin
                    if (w_div_done) begin
                        r_var   <= w_quot;
                        r_state <= S_SQRT_GO;
                    end
                end
                S_SQRT_GO: begin
                    r_state <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT: begin
                    if (w_sqrt_done) begin
                        r_root  <= w_root;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_sat;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_DIRECTED  = 14;
    localparam int N_RANDOM    = 1360;
    localparam int N_QUIET     = 200;
    localparam int N_OVERFLOW  = 40;
    localparam int DRAIN_EVERY = 400;

    typedef struct packed {
        logic [31:0] total;
        logic [31:0] mean;
        logic [63:0] variance;
        logic [31:0] deviation;
        logic        saturated;
    } t_stats;

    typedef struct {
        logic [31:0] sample;
        bit          typed;
        t_stats      stats;
    } t_dir_row;

    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [rmv_pkg::SAMPLE_W-1:0]   i_s_axis_tdata  = '0;  // sample
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    // sample_total, mean_out, variance_out, deviation_out
    logic [rmv_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                           o_m_axis_tuser;        // saturated

    running_mean_variance_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // accumulator copy
    logic [31:0]        acc_count;
    logic signed [31:0] acc_mean;
    logic [63:0]        acc_sum;
    logic               acc_saturated;

    t_stats pending_stats[$];
    int     errors      = 0;
    int     n_sent      = 0;
    int     n_checked   = 0;
    int     n_sat_seen  = 0;
    int     cycle_count = 0;
    bit     idling      = 1'b1;

    t_dir_row directed_rows [N_DIRECTED] = '{
        '{32'h8000_0000, 1'b1, '{32'd1, 32'h8000_0000, 64'd0, 32'd0, 1'b0}},
        '{32'h7FFF_FFFF, 1'b1,
          '{32'd2, 32'hFFFF_FFFF, 64'h7FFF_FFFF_8000_0000, 32'hB504_F333, 1'b0}},
        '{32'h0000_0000, 1'b0, '0},
        '{32'h0000_0000, 1'b0, '0},
        '{32'h0000_0001, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0},
        '{32'h0001_0000, 1'b0, '0},
        '{32'hFFFF_0000, 1'b0, '0},
        '{32'h0080_0000, 1'b0, '0},
        '{32'hFF80_0000, 1'b0, '0},
        '{32'h0055_5555, 1'b0, '0},
        '{32'hFFAA_AAAA, 1'b0, '0},
        '{32'h0000_0001, 1'b0, '0},
        '{32'h0000_0001, 1'b0, '0}
    };

    function automatic t_stats fold_sample(input logic [31:0] sample);
        longint      x;
        longint      delta;
        longint      new_mean;
        longint      rest;
        logic [63:0] mag_d;
        logic [63:0] mag_r;
        logic [63:0] prod;
        logic [63:0] variance;
        logic [31:0] root;
        logic [31:0] trial;
        t_stats      res;
        x = longint'(signed'(sample));
        if (acc_count == '1) begin
            acc_saturated = 1'b1;
        end else begin
            acc_count = acc_count + 32'd1;
            delta     = x - longint'(acc_mean);
            new_mean  = longint'(acc_mean) + delta / longint'({32'd0, acc_count});
            acc_mean  = new_mean[31:0];
            rest      = x - new_mean;
            mag_d     = (delta < 0) ? -delta : delta;
            mag_r     = (rest < 0) ? -rest : rest;
            prod      = mag_d * mag_r;
            if (prod != 0 && ((delta < 0) != (rest < 0))) begin
                acc_sum = (prod > acc_sum) ? 64'd0 : acc_sum - prod;
            end else if (prod > ~acc_sum) begin
                acc_sum       = '1;
                acc_saturated = 1'b1;
            end else begin
                acc_sum = acc_sum + prod;
            end
        end
        variance = (acc_count >= 32'd2) ? acc_sum / ({32'd0, acc_count} - 64'd1) : 64'd0;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if ({32'd0, trial} * {32'd0, trial} <= variance)
                root = trial;
        end
        res.total     = acc_count;
        res.mean      = acc_mean;
        res.variance  = variance;
        res.deviation = root;
        res.saturated = acc_saturated;
        return res;
    endfunction

    // mostly modest magnitudes so the squared sum stays clear of its ceiling
    function automatic logic [31:0] pick_sample();
        logic [31:0] v;
        int          w;
        case ($urandom_range(0, 9))
            0: v = acc_mean;
            1: v = acc_mean + $urandom_range(1, 3) - ($urandom_range(0, 1) ? 32'd0 : 32'd4);
            2: begin
                v = 32'd1 << $urandom_range(0, 23);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: begin
                w = $urandom_range(0, 24);
                v = $urandom & ((32'd1 << w) - 32'd1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // called and returns at a falling edge
    task automatic drive_sample(input logic [31:0] s, input bit typed, input t_stats typed_stats);
        t_stats predicted;
        if (idling && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        predicted = fold_sample(s);
        pending_stats.push_back(typed ? typed_stats : predicted);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_stats.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d items still awaited",
                 cycle_count, pending_stats.size());
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        t_stats exp_s;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected item, got %h", $time, o_m_axis_tdata);
                errors++;
            end else begin
                exp_s = pending_stats.pop_front();
                check_field("sample_total", exp_s.total, o_m_axis_tdata[31:0]);
                check_field("mean_out", exp_s.mean, o_m_axis_tdata[63:32]);
                check_field("variance_out", exp_s.variance, o_m_axis_tdata[127:64]);
                check_field("deviation_out", exp_s.deviation, o_m_axis_tdata[159:128]);
                check_field("saturated", exp_s.saturated, o_m_axis_tuser);
                n_checked++;
                if (o_m_axis_tuser)
                    n_sat_seen++;
            end
        end
    end

    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idling && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    initial begin
        acc_count     = '0;
        acc_mean      = '0;
        acc_sum       = '0;
        acc_saturated = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            drive_sample(directed_rows[i].sample, directed_rows[i].typed,
                         directed_rows[i].stats);
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            drive_sample(pick_sample(), 1'b0, '0);
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain();
        end

        idling = 1'b0;
        for (int i = 0; i < N_QUIET; i++)
            drive_sample(pick_sample(), 1'b0, '0);

        // full-scale swings push the squared sum into its ceiling
        for (int i = 0; i < N_OVERFLOW; i++) begin
            if (i < 10)
                drive_sample((i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, 1'b0, '0);
            else
                drive_sample($urandom, 1'b0, '0);
        end

        drain();
        repeat (300) @(posedge i_clk);

        $display("%0d samples sent: directed extremes, small-scale random, full-scale overflow",
                 n_sent);
        $display("%0d items checked, %0d of them flagged saturated", n_checked, n_sat_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
